// ===== sv/cigar_back_splice_segmenter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Check macros for the CIGAR back-splice segmenter
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CIGAR_BACK_SPLICE_SEGMENTER_UNIT_DEFINES_SVH
`define CIGAR_BACK_SPLICE_SEGMENTER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CBSS_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbss check failed");

// next-cycle implication
`define CBSS_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbss next-cycle check failed");

`else

`define CBSS_CHECK(lbl, ante, cons)
`define CBSS_CHECK_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/cbss_pkg.sv =====
// ----------------------------------------------------------------------------
// cbss_pkg
// Types and character codes shared by the segmenter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cbss_pkg;

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_N     = 8'h4E;

    // sticky record error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CHAR  = 2'd1;
    localparam logic [1:0] ERR_BOUND = 2'd2;

    // a back-splice at this segment count is not split
    localparam logic [7:0] SEG_LIMIT = 8'd254;

    typedef struct packed {
        logic [16:0]        read_start;
        logic [15:0]        read_end;
        logic signed [31:0] ref_start;
        logic [7:0]         first_op;
        logic [7:0]         op_count;
        logic [7:0]         number;
        logic               last;
        logic [1:0]         error;
    } seg_t;

    // up to two segments leave the parser per beat, r0 first
    typedef struct packed {
        logic [1:0] n;
        seg_t       r0;
        seg_t       r1;
    } push_t;

endpackage

`default_nettype wire

// ===== sv/cbss_if.sv =====
// ----------------------------------------------------------------------------
// cbss_if
// Valid/ready channels: CIGAR characters in, segment records out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbss_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cigar_byte;
    logic [30:0] map_pos;
    logic        last_byte;

    modport source (output valid, cigar_byte, map_pos, last_byte, input ready);
    modport sink   (input valid, cigar_byte, map_pos, last_byte, output ready);
endinterface

interface cbss_out_if;
    logic               valid;
    logic               ready;
    logic [16:0]        seg_read_start;
    logic [15:0]        seg_read_end;
    logic signed [31:0] seg_ref_start;
    logic [7:0]         seg_first_op;
    logic [7:0]         seg_op_count;
    logic [7:0]         seg_number;
    logic               last_segment;
    logic [1:0]         error_code;

    modport source (output valid, seg_read_start, seg_read_end, seg_ref_start,
                    seg_first_op, seg_op_count, seg_number, last_segment,
                    error_code, input ready);
    modport sink   (input valid, seg_read_start, seg_read_end, seg_ref_start,
                    seg_first_op, seg_op_count, seg_number, last_segment,
                    error_code, output ready);
endinterface

`default_nettype wire

// ===== sv/cbss_parser.sv =====
// ----------------------------------------------------------------------------
// cbss_parser
// Input register plus one-character parse step: length accumulation, read and
// reference offsets, segment bookkeeping and the sticky error code.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cigar_back_splice_segmenter_unit_defines.svh"

module cbss_parser #(
    parameter int MAX_OPS      = 255,
    parameter int MAX_READ_LEN = 65535
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    cbss_in_if.sink             cigar,
    input  wire logic           room,
    output cbss_pkg::push_t     push
);

    localparam int RW  = $clog2(MAX_READ_LEN + 1);
    localparam int RWX = (RW > 17) ? RW : 17;
    localparam logic [7:0]         OP_LIMIT   = 8'((MAX_OPS > 255) ? 255 : MAX_OPS);
    localparam logic signed [33:0] READ_MAX   = 34'(MAX_READ_LEN);
    localparam logic [RW-1:0]      READ_MAX_W = RW'(MAX_READ_LEN);

    // input register
    logic        s_valid_reg;
    logic [7:0]  s_byte_reg;
    logic [30:0] s_pos_reg;
    logic        s_last_reg;

    // record state
    logic          start_flag_reg,  start_flag_next;
    logic [31:0]   num_reg,         num_next;
    logic          neg_reg,         neg_next;
    logic [30:0]   pos_reg,         pos_next;
    logic [RW-1:0] read_reg,        read_next;
    logic [31:0]   ref_reg,         ref_next;
    logic [7:0]    op_reg,          op_next;
    logic [7:0]    first_reg,       first_next;
    logic [RW-1:0] read_begin_reg,  read_begin_next;
    logic [31:0]   ref_begin_reg,   ref_begin_next;
    logic [7:0]    seg_cnt_reg,     seg_cnt_next;
    logic [1:0]    err_reg,         err_next;

    logic               advance;
    logic               is_digit, is_minus, is_op, is_smi, is_mdn, is_n;
    logic [3:0]         dig4;
    logic [31:0]        num_x10;
    logic [31:0]        len;
    logic               len_neg;
    logic               op_ok;
    logic signed [33:0] read_sum;
    logic               under, over;
    logic [RW-1:0]      read_upd;
    logic               splice, bound_err;
    logic [30:0]        rec_pos;
    cbss_pkg::seg_t     seg_split, seg_final;

    assign advance     = s_valid_reg && room;
    assign cigar.ready = !s_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (cigar.ready)
        begin
            s_valid_reg <= cigar.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cigar.ready && cigar.valid)
        begin
            s_byte_reg <= cigar.cigar_byte;
            s_pos_reg  <= cigar.map_pos;
            s_last_reg <= cigar.last_byte;
        end
    end

    // character classes
    always_comb
    begin
        is_digit = s_byte_reg inside {[cbss_pkg::CH_ZERO:cbss_pkg::CH_NINE]};
        is_minus = (s_byte_reg == cbss_pkg::CH_MINUS);
        is_smi   = s_byte_reg inside {cbss_pkg::CH_S, cbss_pkg::CH_M, cbss_pkg::CH_I};
        is_mdn   = s_byte_reg inside {cbss_pkg::CH_M, cbss_pkg::CH_D, cbss_pkg::CH_N};
        is_n     = (s_byte_reg == cbss_pkg::CH_N);
        is_op    = is_smi || is_mdn;
    end

    // ASCII digits sit at 0x30..0x39, so the low nibble is the digit value
    assign dig4    = s_byte_reg[3:0];
    assign num_x10 = {num_reg[28:0], 3'b000} + {num_reg[30:0], 1'b0} + {28'd0, dig4};
    assign len     = neg_reg ? (32'd0 - num_reg) : num_reg;
    assign len_neg = neg_reg && (num_reg != 32'd0);
    assign op_ok   = (op_reg < OP_LIMIT);
    assign rec_pos = start_flag_reg ? s_pos_reg : pos_reg;

    // read offset moves by the signed length, clamped to [0, MAX_READ_LEN]
    assign read_sum = $signed({{(34-RW){1'b0}}, read_reg}) + $signed({{2{len[31]}}, len});
    assign under    = read_sum[33];
    assign over     = !under && (read_sum > READ_MAX);
    assign read_upd = under ? '0 : (over ? READ_MAX_W : read_sum[RW-1:0]);

    assign splice    = is_n && len_neg && op_ok && (seg_cnt_reg < cbss_pkg::SEG_LIMIT);
    assign bound_err = is_op && (!op_ok
                                 || (is_smi && (under || over))
                                 || (is_n && len_neg && (seg_cnt_reg >= cbss_pkg::SEG_LIMIT)));

    always_comb
    begin
        num_next        = num_reg;
        neg_next        = neg_reg;
        read_next       = read_reg;
        ref_next        = ref_reg;
        op_next         = op_reg;
        first_next      = first_reg;
        read_begin_next = read_begin_reg;
        ref_begin_next  = ref_begin_reg;
        seg_cnt_next    = seg_cnt_reg;
        err_next        = err_reg;

        if (is_digit)
        begin
            num_next = num_x10;
        end
        else if (is_minus)
        begin
            neg_next = 1'b1;
        end
        else
        begin
            num_next = 32'd0;
            neg_next = 1'b0;
            if (is_op && op_ok)
            begin
                op_next = op_reg + 8'd1;
                if (is_smi)
                begin
                    read_next = read_upd;
                end
                if (is_mdn)
                begin
                    ref_next = ref_reg + len;
                end
                if (splice)
                begin
                    first_next      = op_reg + 8'd1;
                    read_begin_next = read_reg;
                    ref_begin_next  = ref_reg + len;
                    seg_cnt_next    = seg_cnt_reg + 8'd1;
                end
            end
        end

        if (err_reg == cbss_pkg::ERR_NONE)
        begin
            if (!is_digit && !is_minus && !is_op)
            begin
                err_next = cbss_pkg::ERR_CHAR;
            end
            else if (bound_err)
            begin
                err_next = cbss_pkg::ERR_BOUND;
            end
        end
    end

    // segment closed by the back-splice: offsets before this op
    always_comb
    begin
        seg_split.read_start = 17'({{(RWX-RW){1'b0}}, read_begin_reg} + RWX'(1));
        seg_split.read_end   = 16'({{(RWX-RW){1'b0}}, read_reg});
        seg_split.ref_start  = $signed({1'b0, rec_pos} + ref_begin_reg);
        seg_split.first_op   = first_reg;
        seg_split.op_count   = op_reg - first_reg;
        seg_split.number     = seg_cnt_reg + 8'd1;
        seg_split.last       = 1'b0;
        seg_split.error      = err_next;
    end

    // final segment of the record: offsets after this character
    always_comb
    begin
        seg_final.read_start = 17'({{(RWX-RW){1'b0}}, read_begin_next} + RWX'(1));
        seg_final.read_end   = 16'({{(RWX-RW){1'b0}}, read_next});
        seg_final.ref_start  = $signed({1'b0, rec_pos} + ref_begin_next);
        seg_final.first_op   = first_next;
        seg_final.op_count   = op_next - first_next;
        seg_final.number     = seg_cnt_next + 8'd1;
        seg_final.last       = 1'b1;
        seg_final.error      = err_next;
    end

    always_comb
    begin
        push.n  = advance ? ({1'b0, splice} + {1'b0, s_last_reg}) : 2'd0;
        push.r0 = splice ? seg_split : seg_final;
        push.r1 = seg_final;
    end

    always_comb
    begin
        start_flag_next = 1'b0;
        pos_next        = rec_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_flag_reg <= 1'b1;
            num_reg        <= '0;
            neg_reg        <= 1'b0;
            pos_reg        <= '0;
            read_reg       <= '0;
            ref_reg        <= '0;
            op_reg         <= '0;
            first_reg      <= '0;
            read_begin_reg <= '0;
            ref_begin_reg  <= '0;
            seg_cnt_reg    <= '0;
            err_reg        <= cbss_pkg::ERR_NONE;
        end
        else if (advance)
        begin
            if (s_last_reg)
            begin
                start_flag_reg <= 1'b1;
                num_reg        <= '0;
                neg_reg        <= 1'b0;
                pos_reg        <= '0;
                read_reg       <= '0;
                ref_reg        <= '0;
                op_reg         <= '0;
                first_reg      <= '0;
                read_begin_reg <= '0;
                ref_begin_reg  <= '0;
                seg_cnt_reg    <= '0;
                err_reg        <= cbss_pkg::ERR_NONE;
            end
            else
            begin
                start_flag_reg <= start_flag_next;
                num_reg        <= num_next;
                neg_reg        <= neg_next;
                pos_reg        <= pos_next;
                read_reg       <= read_next;
                ref_reg        <= ref_next;
                op_reg         <= op_next;
                first_reg      <= first_next;
                read_begin_reg <= read_begin_next;
                ref_begin_reg  <= ref_begin_next;
                seg_cnt_reg    <= seg_cnt_next;
                err_reg        <= err_next;
            end
        end
    end

    `CBSS_CHECK(a_two_segs_order, push.n == 2'd2, push.r1.last && !push.r0.last)
    `CBSS_CHECK_NEXT(a_record_clears, advance && s_last_reg,
                     start_flag_reg && (seg_cnt_reg == 8'd0) && (err_reg == cbss_pkg::ERR_NONE))
    `CBSS_CHECK_NEXT(a_error_sticky, advance && !s_last_reg && (err_reg != cbss_pkg::ERR_NONE),
                     err_reg == $past(err_reg))
    `CBSS_CHECK(a_read_bounded, 1'b1, read_reg <= READ_MAX_W)

endmodule

`default_nettype wire

// ===== sv/cbss_out_fifo.sv =====
// ----------------------------------------------------------------------------
// cbss_out_fifo
// Four-entry result queue; takes up to two segments a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cigar_back_splice_segmenter_unit_defines.svh"

module cbss_out_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire cbss_pkg::push_t push,
    output logic                room,
    cbss_out_if.source          segment
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    cbss_pkg::seg_t  mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     cnt_reg, cnt_next;
    logic            pop;
    cbss_pkg::seg_t  head;

    assign room = (cnt_reg <= (AW+1)'(DEPTH - 2));
    assign pop  = segment.valid && segment.ready;
    assign head = mem_reg[rd_ptr_reg];

    assign cnt_next = cnt_reg + {{(AW-1){1'b0}}, push.n} - {{AW{1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wr_ptr_reg + AW'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + AW'(push.n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    assign segment.valid          = (cnt_reg != '0);
    assign segment.seg_read_start = head.read_start;
    assign segment.seg_read_end   = head.read_end;
    assign segment.seg_ref_start  = head.ref_start;
    assign segment.seg_first_op   = head.first_op;
    assign segment.seg_op_count   = head.op_count;
    assign segment.seg_number     = head.number;
    assign segment.last_segment   = head.last;
    assign segment.error_code     = head.error;

    `CBSS_CHECK(a_no_overflow, 1'b1, cnt_reg <= (AW+1)'(DEPTH))
    `CBSS_CHECK(a_push_has_room, push.n != 2'd0, room)

endmodule

`default_nettype wire

// ===== sv/cigar_back_splice_segmenter_unit.sv =====
// ----------------------------------------------------------------------------
// cigar_back_splice_segmenter_unit
// Parses CIGAR text one character per beat and emits one segment record per
// back-splice (negative N) plus a closing segment at the record's last byte.
//
//   port      dir   beat content
//   cigar     sink  cigar_byte, map_pos, last_byte
//   segment   src   read start/end, ref start, op range, number, last, error
//
// One character per cycle while the output queue has room; a character waits
// in the input register until then; its segments enter the queue as it goes.
// A back-splice on the last byte yields two segments; the four-entry queue
// drains one per cycle while segment.ready is high; input stalls under two free.
// Reset (rst_n low, async) empties both stages and starts a new record.
// ----------------------------------------------------------------------------
`default_nettype none

module cigar_back_splice_segmenter_unit #(
    parameter int MAX_OPS      = 255,
    parameter int MAX_READ_LEN = 65535
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cbss_in_if.sink     cigar,
    cbss_out_if.source  segment
);

    cbss_pkg::push_t push;
    logic            room;

    cbss_parser #(
        .MAX_OPS      (MAX_OPS),
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .cigar (cigar),
        .room  (room),
        .push  (push)
    );

    cbss_out_fifo u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .room    (room),
        .segment (segment)
    );

endmodule

`default_nettype wire
